// ----- rtl/fttb_pkg.sv -----
package fttb_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    // step list of one queued command: up to six steps, indexed by three bits
    localparam int STEP_SLOTS = 8;
    localparam int STEP_W     = 3;

    localparam logic KIND_MACHINE  = 1'b0;
    localparam logic KIND_TERMINAL = 1'b1;

    localparam logic DEST_TERMINAL = 1'b0;
    localparam logic DEST_MACHINE  = 1'b1;

    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_DONT = 8'd254;

    localparam logic [6:0] ASCII_SEMI  = 7'h3B;
    localparam logic [6:0] ASCII_COLON = 7'h3A;

    localparam logic [7:0] KEY_PAIR_HEAD   = 8'o140;
    localparam logic [5:0] CODE_SEMI_TAIL  = 6'o33;
    localparam logic [5:0] CODE_COLON_TAIL = 6'o73;
    localparam logic [5:0] CODE_LOWER_SHIFT = 6'o72;
    localparam logic [5:0] CODE_UPPER_SHIFT = 6'o74;
    localparam logic [8:0] KEY_NONE = 9'h1FF;

    localparam logic [2:0] ESC_RED_LAST   = 3'd4;
    localparam logic [2:0] ESC_PLAIN_LAST = 3'd7;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } item_t;

    typedef struct packed {
        logic       dest;
        logic [7:0] value_res;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        TN_DATA,
        TN_COMMAND,
        TN_OPTION
    } tn_state_t;

    typedef enum logic {
        CMD_SHOW,
        CMD_SEND
    } cmd_op_t;

    // CMD_SHOW: key[6:0] is the machine code with its colour bit
    // CMD_SEND: key is a keymap entry; pair adds a second untagged code
    typedef struct packed {
        cmd_op_t    op;
        logic       pair;
        logic [7:0] key;
        logic [5:0] code2;
    } cmd_t;

    typedef struct packed {
        logic       show;
        logic [6:0] code;
    } step_t;

    typedef enum logic {
        SUB_ESC,
        SUB_GLYPH
    } sub_t;

    typedef enum logic [1:0] {
        GL_TEXT,
        GL_LOWER,
        GL_UPPER
    } gl_kind_t;

    typedef struct packed {
        gl_kind_t        kind;
        logic [1:0]      len;
        logic [2:0][7:0] bytes;
    } glyph_t;

    function automatic glyph_t g_len(input logic [1:0] n, input logic [7:0] a,
                                     input logic [7:0] b, input logic [7:0] c);
        glyph_t g;
        g.kind     = GL_TEXT;
        g.len      = n;
        g.bytes[0] = a;
        g.bytes[1] = b;
        g.bytes[2] = c;
        return g;
    endfunction

    function automatic glyph_t g1(input logic [7:0] a);
        return g_len(2'd1, a, 8'h00, 8'h00);
    endfunction

    function automatic glyph_t g2(input logic [7:0] a, input logic [7:0] b);
        return g_len(2'd2, a, b, 8'h00);
    endfunction

    function automatic glyph_t g3(input logic [7:0] a, input logic [7:0] b,
                                  input logic [7:0] c);
        return g_len(2'd3, a, b, c);
    endfunction

    function automatic glyph_t g_shift(input gl_kind_t k);
        glyph_t g;
        g      = g_len(2'd0, 8'h00, 8'h00, 8'h00);
        g.kind = k;
        return g;
    endfunction

    // index: case flag in bit 6, six-bit code below
    function automatic glyph_t glyph_f(input logic [6:0] idx);
        glyph_t     g;
        logic [7:0] off;
        off = {1'b0, idx};
        g   = g_len(2'd0, 8'h00, 8'h00, 8'h00);
        case (idx)
            7'o000: g = g1(8'h20);
            7'o020: g = g1(8'h30);
            7'o021: g = g1(8'h2F);
            7'o033: g = g1(8'h2C);
            7'o036: g = g1(8'h09);
            7'o040: g = g2(8'hC2, 8'hB7);
            7'o054: g = g1(8'h2D);
            7'o055: g = g1(8'h29);
            7'o056: g = g3(8'hE2, 8'h80, 8'hBE);
            7'o057: g = g1(8'h28);
            7'o072: g = g_shift(GL_LOWER);
            7'o073: g = g1(8'h2E);
            7'o074: g = g_shift(GL_UPPER);
            7'o075: g = g1(8'h08);
            7'o077: g = g2(8'h0D, 8'h0A);
            7'o100: g = g1(8'h20);
            7'o101: g = g1(8'h22);
            7'o102: g = g1(8'h27);
            7'o103: g = g1(8'h7E);
            7'o104: g = g3(8'hE2, 8'h8A, 8'h83);
            7'o105: g = g3(8'hE2, 8'h88, 8'hA8);
            7'o106: g = g3(8'hE2, 8'h88, 8'hA7);
            7'o107: g = g1(8'h3C);
            7'o110: g = g1(8'h3E);
            7'o111: g = g3(8'hE2, 8'h86, 8'h91);
            7'o120: g = g3(8'hE2, 8'h86, 8'h92);
            7'o121: g = g1(8'h3F);
            7'o133: g = g1(8'h3D);
            7'o136: g = g1(8'h09);
            7'o140: g = g1(8'h5F);
            7'o154: g = g1(8'h2B);
            7'o155: g = g1(8'h5D);
            7'o156: g = g1(8'h7C);
            7'o157: g = g1(8'h5B);
            7'o172: g = g_shift(GL_LOWER);
            7'o173: g = g2(8'hC3, 8'h97);
            7'o174: g = g_shift(GL_UPPER);
            7'o175: g = g1(8'h08);
            7'o177: g = g2(8'h0D, 8'h0A);
            default:
            begin
                // letter and digit runs
                if (idx >= 7'o001 && idx <= 7'o011)
                    g = g1(8'h30 + off);
                else if (idx >= 7'o022 && idx <= 7'o031)
                    g = g1(8'h73 + off - 8'o022);
                else if (idx >= 7'o041 && idx <= 7'o051)
                    g = g1(8'h6A + off - 8'o041);
                else if (idx >= 7'o061 && idx <= 7'o071)
                    g = g1(8'h61 + off - 8'o061);
                else if (idx >= 7'o122 && idx <= 7'o131)
                    g = g1(8'h53 + off - 8'o122);
                else if (idx >= 7'o141 && idx <= 7'o151)
                    g = g1(8'h4A + off - 8'o141);
                else if (idx >= 7'o161 && idx <= 7'o171)
                    g = g1(8'h41 + off - 8'o161);
            end
        endcase
        return g;
    endfunction

    // bit 7: upper-case tag, bit 6: lower-case tag, low six bits: code
    function automatic logic [8:0] key_f(input logic [6:0] c);
        logic [8:0] k;
        logic [8:0] off;
        off = {2'b00, c};
        k   = KEY_NONE;
        case (c)
            7'h08: k = 9'o075;
            7'h09: k = 9'o036;
            7'h0D: k = 9'o077;
            7'h20: k = 9'o000;
            7'h21: k = 9'o205;
            7'h22: k = 9'o201;
            7'h23: k = 9'o204;
            7'h26: k = 9'o206;
            7'h27: k = 9'o202;
            7'h28: k = 9'o157;
            7'h29: k = 9'o155;
            7'h2A: k = 9'o273;
            7'h2B: k = 9'o254;
            7'h2C: k = 9'o133;
            7'h2D: k = 9'o154;
            7'h2E: k = 9'o173;
            7'h2F: k = 9'o121;
            7'h30: k = 9'o120;
            7'h3C: k = 9'o207;
            7'h3D: k = 9'o233;
            7'h3E: k = 9'o210;
            7'h3F: k = 9'o221;
            7'h40: k = 9'o140;
            7'h5B: k = 9'o257;
            7'h5C: k = 9'o220;
            7'h5D: k = 9'o255;
            7'h5E: k = 9'o211;
            7'h5F: k = 9'o240;
            7'h60: k = 9'o156;
            7'h7C: k = 9'o256;
            7'h7E: k = 9'o203;
            default:
            begin
                if (c >= 7'h31 && c <= 7'h39)
                    k = 9'o101 + off - 9'h031;
                else if (c >= 7'h41 && c <= 7'h49)
                    k = 9'o261 + off - 9'h041;
                else if (c >= 7'h4A && c <= 7'h52)
                    k = 9'o241 + off - 9'h04A;
                else if (c >= 7'h53 && c <= 7'h5A)
                    k = 9'o222 + off - 9'h053;
                else if (c >= 7'h61 && c <= 7'h69)
                    k = 9'o161 + off - 9'h061;
                else if (c >= 7'h6A && c <= 7'h72)
                    k = 9'o141 + off - 9'h06A;
                else if (c >= 7'h73 && c <= 7'h7A)
                    k = 9'o122 + off - 9'h073;
            end
        endcase
        return k;
    endfunction

    // colour escapes: red is ESC [ 3 1 m, default is ESC [ 3 9 ; 4 9 m
    function automatic logic [7:0] esc_byte(input logic red, input logic [2:0] idx);
        logic [7:0] b;
        case ({red, idx})
            4'b1_000: b = 8'h1B;
            4'b1_001: b = 8'h5B;
            4'b1_010: b = 8'h33;
            4'b1_011: b = 8'h31;
            4'b1_100: b = 8'h6D;
            4'b0_000: b = 8'h1B;
            4'b0_001: b = 8'h5B;
            4'b0_010: b = 8'h33;
            4'b0_011: b = 8'h39;
            4'b0_100: b = 8'h3B;
            4'b0_101: b = 8'h34;
            4'b0_110: b = 8'h39;
            4'b0_111: b = 8'h6D;
            default:  b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/fttb_front.sv -----
module fttb_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  fttb_pkg::item_t item,
    output logic           push,
    output fttb_pkg::cmd_t cmd
);
    import fttb_pkg::*;

    tn_state_t  tn_reg;
    tn_state_t  tn_next;
    logic [8:0] key;

    assign key = key_f(item.value[6:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tn_reg <= TN_DATA;
        end
        else
        begin
            tn_reg <= tn_next;
        end
    end

    always_comb
    begin
        tn_next   = tn_reg;
        push      = 1'b0;
        cmd.op    = CMD_SHOW;
        cmd.pair  = 1'b0;
        cmd.key   = 8'h00;
        cmd.code2 = 6'o00;
        if (take)
        begin
            if (item.kind == KIND_MACHINE)
            begin
                push    = 1'b1;
                cmd.key = {1'b0, item.value[6:0]};
            end
            else
            begin
                case (tn_reg)
                    TN_COMMAND:
                    begin
                        // option byte follows WILL, WONT, DO and DONT only
                        if (item.value >= TN_WILL && item.value <= TN_DONT)
                            tn_next = TN_OPTION;
                        else
                            tn_next = TN_DATA;
                    end
                    TN_OPTION:
                    begin
                        tn_next = TN_DATA;
                    end
                    default:
                    begin
                        tn_next = TN_DATA;
                        if (item.value == TN_IAC)
                        begin
                            tn_next = TN_COMMAND;
                        end
                        else if (item.value[6:0] == ASCII_SEMI)
                        begin
                            push      = 1'b1;
                            cmd.op    = CMD_SEND;
                            cmd.pair  = 1'b1;
                            cmd.key   = KEY_PAIR_HEAD;
                            cmd.code2 = CODE_SEMI_TAIL;
                        end
                        else if (item.value[6:0] == ASCII_COLON)
                        begin
                            push      = 1'b1;
                            cmd.op    = CMD_SEND;
                            cmd.pair  = 1'b1;
                            cmd.key   = KEY_PAIR_HEAD;
                            cmd.code2 = CODE_COLON_TAIL;
                        end
                        else if (key != KEY_NONE)
                        begin
                            push    = 1'b1;
                            cmd.op  = CMD_SEND;
                            cmd.key = key[7:0];
                        end
                    end
                endcase
            end
        end
    end

endmodule

// ----- rtl/fttb_queue.sv -----
module fttb_queue #(
    parameter int DEPTH = fttb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fttb_pkg::cmd_t wr,
    output logic           full,
    input  logic           pop,
    output fttb_pkg::cmd_t rd,
    output logic           avail
);
    import fttb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign avail = (count_reg != '0);
    assign rd    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/fttb_back.sv -----
module fttb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              avail,
    input  fttb_pkg::cmd_t    head,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_ready,
    output fttb_pkg::result_t result
);
    import fttb_pkg::*;

    step_t             steps_reg [STEP_SLOTS];
    step_t             ld_steps  [STEP_SLOTS];
    logic [STEP_W-1:0] ld_n;
    logic [STEP_W-1:0] nsteps_reg;
    logic [STEP_W-1:0] nsteps_next;
    logic [STEP_W-1:0] idx_reg;
    logic [STEP_W-1:0] idx_next;
    sub_t              sub_reg;
    sub_t              sub_next;
    logic [2:0]        cnt_reg;
    logic [2:0]        cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              red_reg;
    logic              red_next;
    logic              upper_reg;
    logic              upper_next;

    logic              hold_valid_reg;
    logic              hold_valid_next;
    logic              hold_dest_reg;
    logic              hold_dest_next;
    logic [7:0]        hold_value_reg;
    logic [7:0]        hold_value_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;
    result_t           out_next;

    logic              has_sh;
    logic [5:0]        sh_code;

    step_t             cur;
    logic              col;
    glyph_t            gl;
    logic              gen_byte;
    logic              gen_end;
    logic              gen_dest;
    logic [7:0]        gen_value;
    logic              p_adv;
    logic              p_esc_done;
    logic              p_cnt_inc;
    logic              p_upper;
    logic              out_free;
    logic              go;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // expand the queue head into put and show steps under the current case flag
    always_comb
    begin
        ld_steps = '{default: '0};
        ld_n     = '0;
        has_sh   = 1'b0;
        sh_code  = 6'o00;
        if (head.key[6] && upper_reg)
        begin
            has_sh  = 1'b1;
            sh_code = CODE_LOWER_SHIFT;
        end
        else if (head.key[7] && !upper_reg)
        begin
            has_sh  = 1'b1;
            sh_code = CODE_UPPER_SHIFT;
        end
        if (head.op == CMD_SHOW)
        begin
            ld_steps[0] = '{1'b1, head.key[6:0]};
            ld_n        = STEP_W'(1);
        end
        else
        begin
            if (has_sh)
            begin
                ld_steps[ld_n] = '{1'b0, {1'b0, sh_code}};
                ld_n           = ld_n + 1'b1;
            end
            ld_steps[ld_n] = '{1'b0, {1'b0, head.key[5:0]}};
            ld_n           = ld_n + 1'b1;
            if (has_sh)
            begin
                ld_steps[ld_n] = '{1'b1, {red_reg, sh_code}};
                ld_n           = ld_n + 1'b1;
            end
            ld_steps[ld_n] = '{1'b1, {red_reg, head.key[5:0]}};
            ld_n           = ld_n + 1'b1;
            if (head.pair)
            begin
                ld_steps[ld_n] = '{1'b0, {1'b0, head.code2}};
                ld_n           = ld_n + 1'b1;
                ld_steps[ld_n] = '{1'b1, {red_reg, head.code2}};
                ld_n           = ld_n + 1'b1;
            end
        end
    end

    // decode the current step into at most one byte
    always_comb
    begin
        cur        = steps_reg[idx_reg];
        col        = cur.code[6];
        gl         = glyph_f({upper_reg, cur.code[5:0]});
        gen_byte   = 1'b0;
        gen_end    = 1'b0;
        gen_dest   = DEST_TERMINAL;
        gen_value  = 8'h00;
        p_adv      = 1'b0;
        p_esc_done = 1'b0;
        p_cnt_inc  = 1'b0;
        p_upper    = upper_reg;
        if (busy_reg)
        begin
            if (idx_reg == nsteps_reg)
            begin
                gen_end = 1'b1;
            end
            else if (!cur.show)
            begin
                gen_byte  = 1'b1;
                gen_dest  = DEST_MACHINE;
                gen_value = {2'b00, cur.code[5:0]};
                p_adv     = 1'b1;
            end
            else if (sub_reg == SUB_ESC && col != red_reg)
            begin
                gen_byte  = 1'b1;
                gen_value = esc_byte(col, cnt_reg);
                if (cnt_reg == (col ? ESC_RED_LAST : ESC_PLAIN_LAST))
                    p_esc_done = 1'b1;
                else
                    p_cnt_inc = 1'b1;
            end
            else
            begin
                case (gl.kind)
                    GL_LOWER:
                    begin
                        p_upper = 1'b0;
                        p_adv   = 1'b1;
                    end
                    GL_UPPER:
                    begin
                        p_upper = 1'b1;
                        p_adv   = 1'b1;
                    end
                    default:
                    begin
                        if (gl.len == 2'd0)
                        begin
                            p_adv = 1'b1;
                        end
                        else
                        begin
                            gen_byte  = 1'b1;
                            gen_value = gl.bytes[cnt_reg[1:0]];
                            if (cnt_reg[1:0] == gl.len - 2'd1)
                                p_adv = 1'b1;
                            else
                                p_cnt_inc = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // one byte is held back so that the final one of a command can carry last
    always_comb
    begin
        out_free = !out_valid_reg || result_ready;
        go       = busy_reg && !(hold_valid_reg && !out_free && (gen_byte || gen_end));
        pop      = avail && (!busy_reg || (go && gen_end));

        busy_next   = busy_reg;
        nsteps_next = nsteps_reg;
        idx_next    = idx_reg;
        sub_next    = sub_reg;
        cnt_next    = cnt_reg;
        red_next    = red_reg;
        upper_next  = upper_reg;
        if (go)
        begin
            upper_next = p_upper;
            if (p_adv)
            begin
                idx_next = idx_reg + 1'b1;
                sub_next = SUB_ESC;
                cnt_next = 3'd0;
            end
            else if (p_esc_done)
            begin
                red_next = col;
                sub_next = SUB_GLYPH;
                cnt_next = 3'd0;
            end
            else if (p_cnt_inc)
            begin
                cnt_next = cnt_reg + 3'd1;
            end
            if (gen_end)
                busy_next = 1'b0;
        end
        if (pop)
        begin
            busy_next   = 1'b1;
            nsteps_next = ld_n;
            idx_next    = '0;
            sub_next    = SUB_ESC;
            cnt_next    = 3'd0;
        end

        out_valid_next  = out_valid_reg && !result_ready;
        out_next        = out_reg;
        hold_valid_next = hold_valid_reg;
        hold_dest_next  = hold_dest_reg;
        hold_value_next = hold_value_reg;
        if (go && gen_byte)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = '{hold_dest_reg, hold_value_reg, 1'b0};
            end
            hold_valid_next = 1'b1;
            hold_dest_next  = gen_dest;
            hold_value_next = gen_value;
        end
        else if (go && gen_end && hold_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_next        = '{hold_dest_reg, hold_value_reg, 1'b1};
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            steps_reg <= ld_steps;
        end
        hold_dest_reg  <= hold_dest_next;
        hold_value_reg <= hold_value_next;
        out_reg        <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            nsteps_reg     <= '0;
            idx_reg        <= '0;
            sub_reg        <= SUB_ESC;
            cnt_reg        <= 3'd0;
            red_reg        <= 1'b0;
            upper_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            nsteps_reg     <= nsteps_next;
            idx_reg        <= idx_next;
            sub_reg        <= sub_next;
            cnt_reg        <= cnt_next;
            red_reg        <= red_next;
            upper_reg      <= upper_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

// ----- rtl/fiodec_telnet_terminal_bridge.sv -----
// An item's results pass through the command queue, the back-end step registers, a
// one-byte hold register and the output register. The back-end sequencer gives at most
// one result per cycle while result_ready lets it, and handles one command at a time.
// Items are taken every cycle while the command queue (QUEUE_DEPTH entries) has room.
// Reset (rst_n low, asynchronous): plain telnet state, default colour, lower case,
// empty queue and no pending result.
module fiodec_telnet_terminal_bridge #(
    parameter int QUEUE_DEPTH = fttb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  fttb_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output fttb_pkg::result_t result
);
    import fttb_pkg::*;

    logic take;
    logic push;
    cmd_t cmd;
    logic full;
    logic pop;
    cmd_t head;
    logic avail;

    assign item_ready = !full;
    assign take       = item_valid && item_ready;

    fttb_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .push  (push),
        .cmd   (cmd)
    );

    fttb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wr    (cmd),
        .full  (full),
        .pop   (pop),
        .rd    (head),
        .avail (avail)
    );

    fttb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .avail        (avail),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
